/* rtl/core/sgc_pkg.sv */
// sgc_pkg: shared constants for the separable 3-d gaussian filter
// holds default sizes, action codes and register indexes; no dependencies
package sgc_pkg;

  localparam int MAX_X_DEF      = 64;
  localparam int MAX_Y_DEF      = 64;
  localparam int MAX_Z_DEF      = 32;
  localparam int MAX_RADIUS_DEF = 8;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TAP_BITS_DEF   = 16;

  // item actions
  localparam logic [1:0] ACT_TAP   = 2'd0;
  localparam logic [1:0] ACT_VOXEL = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // tap axes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SIZE_X   = 3'd0;
  localparam logic [2:0] REG_SIZE_Y   = 3'd1;
  localparam logic [2:0] REG_SIZE_Z   = 3'd2;
  localparam logic [2:0] REG_RADIUS_X = 3'd3;
  localparam logic [2:0] REG_RADIUS_Y = 3'd4;
  localparam logic [2:0] REG_RADIUS_Z = 3'd5;

  localparam int CFG_DATA_W = 7;

endpackage

/* rtl/core/sgc_divider.sv */
// sgc_divider: restoring divider, one quotient bit per cycle, rounds to nearest
// computes (num + den/2) / den for unsigned operands; uses no package items
module sgc_divider #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 21
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [NUM_W:0]     quot
);

  localparam int NW = NUM_W + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]  dvd;
  logic [DEN_W:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [CW-1:0]  cnt;
  logic           run;
  logic [DEN_W:0] rs;
  logic           ge;

  assign rs   = {rem[DEN_W-1:0], dvd[NW-1]};
  assign ge   = rs >= {1'b0, dreg};
  assign quot = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        done <= 1'b0;
        run  <= 1'b1;
        cnt  <= CW'(NW);
        dreg <= den;
        rem  <= '0;
        // rounding bias added before the bit loop
        dvd  <= {1'b0, num} + NW'(den >> 1);
      end else if (run) begin
        rem <= ge ? rs - {1'b0, dreg} : rs;
        dvd <= {dvd[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  dvd_ok_a: assert property (@(posedge clk) disable iff (rst)
    start |=> run && !done)
    else $error("divider did not start");
  done_a: assert property (@(posedge clk) disable iff (rst)
    done |-> !run)
    else $error("divider done while running");
  cnt_a: assert property (@(posedge clk) disable iff (rst)
    run |-> cnt != '0)
    else $error("divider count ran out");

endmodule

/* rtl/core/separable_3d_gaussian_conv.sv */
// separable_3d_gaussian_conv: volume store with in-place separable filtering
// along x, y and z using border-normalized kernels; uses sgc_pkg, sgc_divider
//
// Tap and voxel write items are taken one per cycle while the block is idle and
// no read is pending. A read item stalls the input while the registered volume
// read is pending and returns one result item. A run item keeps the block busy
// until all three axes are done: each filtered line is first copied voxel by
// voxel into the line buffer, then each output voxel walks its kernel taps on
// the shared multiply-accumulate, is rounded, goes through the bit-serial
// divider where the kernel is cut by a border, and is written back. The volume
// memory has one read port and one write port.
module separable_3d_gaussian_conv #(
  parameter int MAX_X       = sgc_pkg::MAX_X_DEF,
  parameter int MAX_Y       = sgc_pkg::MAX_Y_DEF,
  parameter int MAX_Z       = sgc_pkg::MAX_Z_DEF,
  parameter int MAX_RADIUS  = sgc_pkg::MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = sgc_pkg::SAMPLE_BITS_DEF,
  parameter int TAP_BITS    = sgc_pkg::TAP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           action,
  input  logic [1:0]           axis,
  input  logic [4:0]           tap_index,
  input  logic [TAP_BITS-1:0]  tap_value,
  input  logic [16:0]          voxel_index,
  input  logic signed [SAMPLE_BITS-1:0] voxel_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [16:0]          result_index,
  output logic signed [SAMPLE_BITS-1:0] result_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [sgc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TAPS      = 2 * MAX_RADIUS + 1;
  localparam int VOL_DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int VA_W      = $clog2(VOL_DEPTH) < 1 ? 1 : $clog2(VOL_DEPTH);
  localparam int LINE_DEPTH = MAX_X > MAX_Y ? (MAX_X > MAX_Z ? MAX_X : MAX_Z)
                                            : (MAX_Y > MAX_Z ? MAX_Y : MAX_Z);
  localparam int LP   = $clog2(LINE_DEPTH) < 1 ? 1 : $clog2(LINE_DEPTH);
  localparam int LN   = $clog2(LINE_DEPTH + 1);
  localparam int XW   = $clog2(MAX_X + 1);
  localparam int YW   = $clog2(MAX_Y + 1);
  localparam int ZW   = $clog2(MAX_Z + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int JW   = $clog2(TAPS);
  localparam int TDEPTH = 3 * TAPS;
  localparam int TI   = $clog2(TDEPTH);
  localparam int PROD_W = SAMPLE_BITS + TAP_BITS + 1;
  localparam int SUM_W  = PROD_W + $clog2(TAPS);
  localparam int NORM_W = TAP_BITS + $clog2(TAPS);
  localparam int RES_W  = SUM_W + 2;
  localparam int CW   = LN + RW + 1;
  localparam logic signed [RES_W-1:0] SMAX =
    RES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] SMIN = -SMAX - RES_W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_PLANE, S_AXIS, S_LINE, S_LD_RD, S_LD_WR, S_PT, S_TAP_RD,
    S_TAP_MUL, S_TAP_ADD, S_ABS, S_RND, S_DIV, S_WB, S_NEXT
  } state_t;

  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] c;
    c = v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
    return SAMPLE_BITS'(c);
  endfunction

  // configuration
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [ZW-1:0] sz;
  logic [RW-1:0] rx, ry, rz;

  function automatic logic [31:0] clampv(input logic [31:0] v, input int lo, input int hi);
    return v < 32'(lo) ? 32'(lo) : (v > 32'(hi) ? 32'(hi) : v);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= XW'(MAX_X);
      sy <= YW'(MAX_Y);
      sz <= ZW'(MAX_Z);
      rx <= '0;
      ry <= '0;
      rz <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sgc_pkg::REG_SIZE_X:   sx <= XW'(clampv(32'(cfg_data), 1, MAX_X));
        sgc_pkg::REG_SIZE_Y:   sy <= YW'(clampv(32'(cfg_data), 1, MAX_Y));
        sgc_pkg::REG_SIZE_Z:   sz <= ZW'(clampv(32'(cfg_data[5:0]), 1, MAX_Z));
        sgc_pkg::REG_RADIUS_X: rx <= RW'(clampv(32'(cfg_data[3:0]), 0, MAX_RADIUS));
        sgc_pkg::REG_RADIUS_Y: ry <= RW'(clampv(32'(cfg_data[3:0]), 0, MAX_RADIUS));
        sgc_pkg::REG_RADIUS_Z: rz <= RW'(clampv(32'(cfg_data[3:0]), 0, MAX_RADIUS));
        default: ;
      endcase
    end
  end

  // item side
  state_t state;
  logic   busy, rd_pend, rd_ok, acc;
  logic [16:0] rd_idx;
  logic [31:0] vi32;
  logic        vi_ok;

  assign busy  = state != S_IDLE;
  assign in_stall = busy || rd_pend ||
                    (action == sgc_pkg::ACT_READ && out_valid && out_stall);
  assign acc   = in_valid && !in_stall;
  assign vi32  = 32'(voxel_index);
  assign vi_ok = vi32 < 32'(VOL_DEPTH);

  // memories
  logic [SAMPLE_BITS-1:0] vol_mem [VOL_DEPTH];
  logic [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];
  logic [TAP_BITS-1:0]    tap_mem [TDEPTH];
  logic [SAMPLE_BITS-1:0] vol_q, line_q;
  logic [TAP_BITS-1:0]    tap_q;
  logic                   vol_we, line_we, tap_we;
  logic [VA_W-1:0]        vol_waddr, vol_raddr;
  logic [SAMPLE_BITS-1:0] vol_wdata;
  logic [LP-1:0]          line_waddr, line_raddr;
  logic [TI-1:0]          tap_waddr, tap_raddr;

  // sequencer registers
  logic [VA_W-1:0] plane, ob, ib, istep, ostep, lda, wba, stride;
  logic [LN-1:0]   len, ninner, nouter, ic, oc, p, q;
  logic [RW-1:0]   r;
  logic [1:0]      ax;
  logic [TI-1:0]   tbase;
  logic [JW-1:0]   j, jhi;
  logic            full, neg;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]         mag;
  logic [NORM_W-1:0]        norm;
  logic signed [RES_W-1:0]  res;
  logic                     div_start, div_done;
  logic [SUM_W:0]           quot, qfull;

  // per-position tap window
  logic [CW-1:0] pw, rw_, lw, remw, jlo_w, jhi_w, qlo_w;
  assign pw    = CW'(p);
  assign rw_   = CW'(r);
  assign lw    = CW'(len);
  assign remw  = lw - CW'(1) - pw;
  assign jlo_w = pw < rw_ ? rw_ - pw : '0;
  assign jhi_w = remw < rw_ ? rw_ + remw : rw_ + rw_;
  assign qlo_w = pw < rw_ ? '0 : pw - rw_;

  assign qfull = ({1'b0, mag} + ((SUM_W + 1)'(1) << (TAP_BITS - 1))) >> TAP_BITS;

  // memory port muxing
  always_comb begin
    vol_we    = 1'b0;
    vol_waddr = vi32[VA_W-1:0];
    vol_wdata = sat(RES_W'(voxel_value));
    vol_raddr = busy ? lda : vi32[VA_W-1:0];
    tap_we    = 1'b0;
    tap_waddr = TI'(32'(axis) * 32'(TAPS) + 32'(tap_index));
    if (acc && action == sgc_pkg::ACT_VOXEL && vi_ok) begin
      vol_we = 1'b1;
    end
    if (acc && action == sgc_pkg::ACT_TAP && axis != 2'd3 && 32'(tap_index) < 32'(TAPS)) begin
      tap_we = 1'b1;
    end
    if (state == S_WB) begin
      vol_we    = 1'b1;
      vol_waddr = wba;
      vol_wdata = sat(res);
    end
    line_we    = state == S_LD_WR;
    line_waddr = p[LP-1:0];
    line_raddr = q[LP-1:0];
    tap_raddr  = tbase + TI'(j);
    div_start  = state == S_RND && !full && norm != '0;
  end

  always_ff @(posedge clk) begin
    if (vol_we) vol_mem[vol_waddr] <= vol_wdata;
    vol_q <= vol_mem[vol_raddr];
  end

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_waddr] <= vol_q;
    line_q <= line_mem[line_raddr];
  end

  always_ff @(posedge clk) begin
    if (tap_we) tap_mem[tap_waddr] <= tap_value;
    tap_q <= tap_mem[tap_raddr];
  end

  sgc_divider #(
    .NUM_W(SUM_W),
    .DEN_W(NORM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (mag),
    .den  (norm),
    .done (div_done),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // read path
      rd_pend <= acc && action == sgc_pkg::ACT_READ;
      if (acc && action == sgc_pkg::ACT_READ) begin
        rd_idx <= voxel_index;
        rd_ok  <= vi_ok;
      end
      if (rd_pend) begin
        out_valid    <= 1'b1;
        result_index <= rd_idx;
        result_value <= rd_ok ? $signed(vol_q) : '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (acc && action == sgc_pkg::ACT_RUN) state <= S_PLANE;
        end
        S_PLANE: begin
          plane <= VA_W'(sx) * VA_W'(sy);
          ax    <= sgc_pkg::AX_X;
          state <= S_AXIS;
        end
        S_AXIS: begin
          ob <= '0;
          ib <= '0;
          ic <= '0;
          oc <= '0;
          case (ax)
            sgc_pkg::AX_X: begin
              r <= rx; len <= LN'(sx); stride <= VA_W'(1);
              ninner <= LN'(sy); istep <= VA_W'(sx);
              nouter <= LN'(sz); ostep <= plane;
              tbase <= '0;
            end
            sgc_pkg::AX_Y: begin
              r <= ry; len <= LN'(sy); stride <= VA_W'(sx);
              ninner <= LN'(sx); istep <= VA_W'(1);
              nouter <= LN'(sz); ostep <= plane;
              tbase <= TI'(TAPS);
            end
            default: begin
              r <= rz; len <= LN'(sz); stride <= plane;
              ninner <= LN'(sx); istep <= VA_W'(1);
              nouter <= LN'(sy); ostep <= VA_W'(sx);
              tbase <= TI'(2 * TAPS);
            end
          endcase
          if ((ax == sgc_pkg::AX_X && rx == '0) || (ax == sgc_pkg::AX_Y && ry == '0) ||
              (ax == sgc_pkg::AX_Z && rz == '0)) begin
            if (ax == sgc_pkg::AX_Z) state <= S_IDLE;
            else ax <= ax + 2'd1;
          end else begin
            state <= S_LINE;
          end
        end
        S_LINE: begin
          lda   <= ob + ib;
          wba   <= ob + ib;
          p     <= '0;
          state <= S_LD_RD;
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: begin
          lda <= lda + stride;
          if (p == len - LN'(1)) begin
            p     <= '0;
            state <= S_PT;
          end else begin
            p     <= p + LN'(1);
            state <= S_LD_RD;
          end
        end
        S_PT: begin
          j     <= JW'(jlo_w);
          jhi   <= JW'(jhi_w);
          q     <= LN'(qlo_w);
          full  <= jlo_w == '0 && jhi_w == rw_ + rw_;
          sum   <= '0;
          norm  <= '0;
          state <= S_TAP_RD;
        end
        S_TAP_RD: state <= S_TAP_MUL;
        S_TAP_MUL: begin
          prod  <= $signed(line_q) * $signed({1'b0, tap_q});
          norm  <= norm + NORM_W'(tap_q);
          state <= S_TAP_ADD;
        end
        S_TAP_ADD: begin
          sum <= sum + SUM_W'(prod);
          if (j == jhi) begin
            state <= S_ABS;
          end else begin
            j     <= j + JW'(1);
            q     <= q + LN'(1);
            state <= S_TAP_RD;
          end
        end
        S_ABS: begin
          neg   <= sum < 0;
          mag   <= sum < 0 ? SUM_W'(-sum) : SUM_W'(sum);
          state <= S_RND;
        end
        S_RND: begin
          if (full) begin
            res   <= neg ? -RES_W'(qfull) : RES_W'(qfull);
            state <= S_WB;
          end else if (norm == '0) begin
            res   <= '0;
            state <= S_WB;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res   <= neg ? -RES_W'(quot) : RES_W'(quot);
            state <= S_WB;
          end
        end
        S_WB: begin
          wba <= wba + stride;
          if (p == len - LN'(1)) begin
            state <= S_NEXT;
          end else begin
            p     <= p + LN'(1);
            state <= S_PT;
          end
        end
        S_NEXT: begin
          if (ic == ninner - LN'(1)) begin
            ic <= '0;
            ib <= '0;
            if (oc == nouter - LN'(1)) begin
              if (ax == sgc_pkg::AX_Z) state <= S_IDLE;
              else begin
                ax    <= ax + 2'd1;
                state <= S_AXIS;
              end
            end else begin
              oc    <= oc + LN'(1);
              ob    <= ob + ostep;
              state <= S_LINE;
            end
          end else begin
            ic    <= ic + LN'(1);
            ib    <= ib + istep;
            state <= S_LINE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  busy_stall_a: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("item taken during a run");
  rd_out_a: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> out_valid)
    else $error("read item lost");
  div_st_a: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV)
    else $error("divider started outside rounding");
  wb_a: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> vol_we && !(acc && action == sgc_pkg::ACT_VOXEL))
    else $error("write back port clash");

endmodule

/* tb/sgc_checker.sv */
`timescale 1ns / 1ps
// sgc_checker: watches the item, result and register channels of the filter
// keeps its own copy of the volume, taps and sizes; uses sgc_pkg
module sgc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         action,
  input  logic [1:0]         axis,
  input  logic [4:0]         tap_index,
  input  logic [15:0]        tap_value,
  input  logic [16:0]        voxel_index,
  input  logic signed [15:0] voxel_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [16:0]        result_index,
  input  logic signed [15:0] result_value,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output int                 errors,
  output int                 waiting
);

  localparam int TAPS_AXIS = 2 * sgc_pkg::MAX_RADIUS_DEF + 1;

  typedef struct {
    logic [16:0]        index;
    logic signed [15:0] value;
  } voxel_read_t;

  logic signed [15:0] volume_model [0:131071];
  logic [15:0]        tap_model [0:3*TAPS_AXIS-1];
  int                 dim_x, dim_y, dim_z, rad_x, rad_y, rad_z;
  voxel_read_t        read_results [$];

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // round to nearest, ties away from zero
  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic void smooth_line(int base, int stride, int len, int r, int kbase);
    longint line [0:63];
    longint acc;
    longint norm;
    longint res;
    int lo, hi;
    for (int p = 0; p < len; p++) line[p] = volume_model[base + p * stride];
    for (int p = 0; p < len; p++) begin
      lo = p < r ? -p : -r;
      hi = (len - 1 - p) < r ? (len - 1 - p) : r;
      acc = 0;
      norm = 0;
      for (int o = lo; o <= hi; o++) begin
        acc += line[p + o] * longint'(tap_model[kbase + o + r]);
        norm += tap_model[kbase + o + r];
      end
      if (lo == -r && hi == r) res = div_round(acc, 65536);
      else if (norm == 0) res = 0;
      else res = div_round(acc, norm);
      volume_model[base + p * stride] = sat16(res);
    end
  endfunction

  function automatic void smooth_volume();
    if (rad_x != 0)
      for (int a = 0; a < dim_y * dim_z; a++) smooth_line(a * dim_x, 1, dim_x, rad_x, 0);
    if (rad_y != 0)
      for (int b = 0; b < dim_z; b++)
        for (int a = 0; a < dim_x; a++)
          smooth_line(a + b * dim_x * dim_y, dim_x, dim_y, rad_y, TAPS_AXIS);
    if (rad_z != 0)
      for (int a = 0; a < dim_x * dim_y; a++)
        smooth_line(a, dim_x * dim_y, dim_z, rad_z, 2 * TAPS_AXIS);
  endfunction

  assign waiting = read_results.size();

  always @(posedge clk) begin
    voxel_read_t exp_rd;
    if (rst) begin
      errors = 0;
      dim_x <= sgc_pkg::MAX_X_DEF; dim_y <= sgc_pkg::MAX_Y_DEF; dim_z <= sgc_pkg::MAX_Z_DEF;
      rad_x <= 0; rad_y <= 0; rad_z <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sgc_pkg::REG_SIZE_X:   dim_x <= clamp(cfg_data, 1, sgc_pkg::MAX_X_DEF);
          sgc_pkg::REG_SIZE_Y:   dim_y <= clamp(cfg_data, 1, sgc_pkg::MAX_Y_DEF);
          sgc_pkg::REG_SIZE_Z:   dim_z <= clamp(cfg_data[5:0], 1, sgc_pkg::MAX_Z_DEF);
          sgc_pkg::REG_RADIUS_X: rad_x <= clamp(cfg_data[3:0], 0, sgc_pkg::MAX_RADIUS_DEF);
          sgc_pkg::REG_RADIUS_Y: rad_y <= clamp(cfg_data[3:0], 0, sgc_pkg::MAX_RADIUS_DEF);
          sgc_pkg::REG_RADIUS_Z: rad_z <= clamp(cfg_data[3:0], 0, sgc_pkg::MAX_RADIUS_DEF);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (action)
          sgc_pkg::ACT_TAP:
            if (axis != 2'd3 && tap_index < TAPS_AXIS)
              tap_model[axis * TAPS_AXIS + tap_index] = tap_value;
          sgc_pkg::ACT_VOXEL: volume_model[voxel_index] = voxel_value;
          sgc_pkg::ACT_RUN:   smooth_volume();
          sgc_pkg::ACT_READ: begin
            exp_rd.index = voxel_index;
            exp_rd.value = volume_model[voxel_index];
            read_results.push_back(exp_rd);
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (read_results.size() == 0) begin
          $error("result item with nothing expected: index %0d", result_index);
          errors++;
        end else begin
          exp_rd = read_results.pop_front();
          if (result_index !== exp_rd.index) begin
            $error("result_index expected %0d actual %0d", exp_rd.index, result_index);
            errors++;
          end
          if (result_value !== exp_rd.value) begin
            $error("result_value expected %0d actual %0d", exp_rd.value, result_value);
            errors++;
          end
        end
      end
    end
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: stimulus and verdict for separable_3d_gaussian_conv
// depends on sgc_pkg, the block and sgc_checker
module testbench;

  logic               clk, rst;
  logic               in_valid, in_stall;
  logic [1:0]         action, axis;
  logic [4:0]         tap_index;
  logic [15:0]        tap_value;
  logic [16:0]        voxel_index;
  logic signed [15:0] voxel_value;
  logic               out_valid, out_stall;
  logic [16:0]        result_index;
  logic signed [15:0] result_value;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [6:0]         cfg_data;
  int                 errors, waiting;

  bit                 voxel_known [0:131071];
  int                 known_list [$];
  int                 sx, sy, sz;
  bit                 no_idle, long_hold;

  separable_3d_gaussian_conv i_dut (.*);

  sgc_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int cyc = 0; cyc < 6000000; cyc++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // result side: random stall per item, one long hold on request
  initial begin
    int w;
    bit held;
    held = 0;
    out_stall = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold && !held) begin
        w = 400;
        held = 1;
      end else w = no_idle ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  task automatic send(int act, int ax, int ti, int tv, int vi, int vv);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    action <= 2'(act); axis <= 2'(ax); tap_index <= 5'(ti); tap_value <= 16'(tv);
    voxel_index <= 17'(vi); voxel_value <= 16'(vv);
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic put_voxel(int idx, int v);
    send(sgc_pkg::ACT_VOXEL, $urandom, $urandom, $urandom, idx, v);
    if (!voxel_known[idx]) begin
      voxel_known[idx] = 1;
      known_list.push_back(idx);
    end
  endtask

  task automatic read_voxel(int idx);
    send(sgc_pkg::ACT_READ, $urandom, $urandom, $urandom, idx, $urandom);
  endtask

  // the filter reads the whole region in use, so every voxel of it must be set
  task automatic run_filter();
    for (int i = 0; i < sx * sy * sz; i++)
      if (!voxel_known[i]) put_voxel(i, $urandom);
    send(sgc_pkg::ACT_RUN, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // a read after a run only returns once the run is done
  task automatic drain();
    read_voxel(0);
    in_valid <= 0;
    while (waiting != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(int idx, int val);
    logic [6:0] v;
    v = 7'(val);
    cfg_valid <= 1; cfg_index <= 3'(idx); cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    case (3'(idx))
      sgc_pkg::REG_SIZE_X:
        sx = v == 0 ? 1 : (v > sgc_pkg::MAX_X_DEF ? sgc_pkg::MAX_X_DEF : v);
      sgc_pkg::REG_SIZE_Y:
        sy = v == 0 ? 1 : (v > sgc_pkg::MAX_Y_DEF ? sgc_pkg::MAX_Y_DEF : v);
      sgc_pkg::REG_SIZE_Z:
        sz = v[5:0] == 0 ? 1 : (v[5:0] > sgc_pkg::MAX_Z_DEF ? sgc_pkg::MAX_Z_DEF : v[5:0]);
      default: ;
    endcase
  endtask

  task automatic set_shape(int x, int y, int z, int rx, int ry, int rz);
    write_reg(sgc_pkg::REG_SIZE_X, x);
    write_reg(sgc_pkg::REG_SIZE_Y, y);
    write_reg(sgc_pkg::REG_SIZE_Z, z);
    write_reg(sgc_pkg::REG_RADIUS_X, rx);
    write_reg(sgc_pkg::REG_RADIUS_Y, ry);
    write_reg(sgc_pkg::REG_RADIUS_Z, rz);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      send(sgc_pkg::ACT_TAP, $urandom_range(0, 3), $urandom_range(0, 31), $urandom,
           $urandom, $urandom);
    else if (r < 50)
      put_voxel($urandom_range(0, 9) < 8 ? $urandom_range(0, 255) : $urandom_range(0, 131071),
                $urandom);
    else if (r < 97)
      read_voxel(known_list[$urandom_range(0, known_list.size() - 1)]);
    else
      run_filter();
  endtask

  initial begin
    in_valid = 0; action = sgc_pkg::ACT_TAP; axis = sgc_pkg::AX_X; tap_index = 0;
    tap_value = 0; voxel_index = 0; voxel_value = 0; cfg_valid = 0;
    cfg_index = sgc_pkg::REG_SIZE_X; cfg_data = 0;
    no_idle = 0; long_hold = 0;
    sx = sgc_pkg::MAX_X_DEF; sy = sgc_pkg::MAX_Y_DEF; sz = sgc_pkg::MAX_Z_DEF;
    rst = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: tiny volume with all axes active
    set_shape(4, 3, 2, 1, 1, 1);
    for (int a = 0; a < 3; a++)
      for (int t = 0; t < 17; t++) send(sgc_pkg::ACT_TAP, a, t, $urandom, 0, 0);
    // full x kernel at max weight saturates, y taps up to the center zero the norm
    for (int t = 0; t < 3; t++) send(sgc_pkg::ACT_TAP, sgc_pkg::AX_X, t, 16'hFFFF, 0, 0);
    send(sgc_pkg::ACT_TAP, sgc_pkg::AX_Y, 0, 16'h0000, 0, 0);
    send(sgc_pkg::ACT_TAP, sgc_pkg::AX_Y, 1, 16'h0000, 0, 0);
    // bad tap addresses are ignored
    send(sgc_pkg::ACT_TAP, 2'd3, 0, 16'h1234, 0, 0);
    send(sgc_pkg::ACT_TAP, sgc_pkg::AX_X, 5'd31, 16'h1234, 0, 0);
    send(sgc_pkg::ACT_TAP, sgc_pkg::AX_Z, 5'd17, 16'h1234, 0, 0);
    for (int i = 0; i < 24; i++)
      put_voxel(i, i[0] ? 16'sh7FFF : -16'sh8000);
    put_voxel(131071, -16'sh8000);
    put_voxel(65536, 16'sh7FFF);
    read_voxel(131071);
    read_voxel(65536);
    read_voxel(5);
    run_filter();
    for (int i = 0; i < 24; i += 5) read_voxel(i);
    drain();

    // register extremes, long lines along x and z
    set_shape(127, 0, 1, 15, 0, 0);
    run_filter();
    for (int i = 0; i < 64; i += 9) read_voxel(i);
    drain();
    set_shape(1, 1, 63, 0, 0, 8);
    run_filter();
    for (int i = 0; i < 32; i += 7) read_voxel(i);
    drain();

    // full-rate stretch, then a long result hold while items keep coming
    no_idle = 1;
    long_hold = 1;
    for (int i = 0; i < 40; i++) read_voxel(known_list[$urandom_range(0, known_list.size() - 1)]);
    no_idle = 0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_shape($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 3),
                $urandom_range(0, 9) < 7 ? $urandom_range(0, 8) : $urandom_range(0, 15),
                $urandom_range(0, 8), $urandom_range(0, 8));
      no_idle = ph[0];
      for (int i = 0; i < 70; i++) random_item();
      no_idle = 0;
      drain();
    end

    in_valid <= 0;
    while (waiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/sgc_pkg.sv
rtl/core/sgc_divider.sv
rtl/core/separable_3d_gaussian_conv.sv
tb/sgc_checker.sv
tb/testbench.sv
